// File: hdl/ppd_pkg.sv
// Shared types and constants for the PPM P6 stream decoder.
package ppd_pkg;

  // Default limits
  localparam int unsigned MAX_DIM_DEF    = 4096;
  localparam int unsigned MAX_DIGITS_DEF = 10;

  // Fixed field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned ARGB_W = 32;
  localparam int unsigned DIM_W  = 13;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  // Error codes
  typedef enum logic [1:0] {
    ERR_MAGIC  = 2'd0,
    ERR_SEP    = 2'd1,
    ERR_NUMBER = 2'd2,
    ERR_SIZE   = 2'd3
  } err_e;

  // One input request
  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              start_of_file;
  } item_t;

  // One result
  typedef struct packed {
    kind_e             kind;
    logic [ARGB_W-1:0] pixel_argb;
    logic [DIM_W-1:0]  image_width;
    logic [DIM_W-1:0]  image_height;
    err_e              error_code;
    logic              last_pixel;
  } res_t;

endpackage

// File: hdl/ppd_if.sv
// Stream channel interfaces for file bytes and decoded results.
interface ppd_in_if;
  logic                       valid;
  logic                       ready;
  logic [ppd_pkg::BYTE_W-1:0] in_byte;
  logic                       start_of_file;

  modport source (output valid, output in_byte, output start_of_file, input ready);
  modport sink   (input valid, input in_byte, input start_of_file, output ready);
endinterface

interface ppd_out_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 kind;
  logic [ppd_pkg::ARGB_W-1:0] pixel_argb;
  logic [ppd_pkg::DIM_W-1:0]  image_width;
  logic [ppd_pkg::DIM_W-1:0]  image_height;
  logic [1:0]                 error_code;
  logic                       last_pixel;

  modport source (output valid, output kind, output pixel_argb, output image_width,
                  output image_height, output error_code, output last_pixel,
                  input ready);
  modport sink   (input valid, input kind, input pixel_argb, input image_width,
                  input image_height, input error_code, input last_pixel,
                  output ready);
endinterface

// File: hdl/ppm_p6_stream_decoder.sv
// Top level of the PPM P6 stream decoder.
//
//   channel | dir | payload                                    | handshake
//   in_i    | in  | in_byte, start_of_file                     | valid/ready
//   out_o   | out | kind, pixel_argb, image_width, image_height,| valid/ready
//           |     | error_code, last_pixel                     |
//
// One byte is taken per cycle unless a result held in the output register is not
// taken; a byte's result, if it gives one, passes the input register and the
// parse step into the result register, where it is offered until it is taken.
// The parse step between the two registers is combinational.
// Reset clears the parse state to wait for the magic 'P' and empties both stages.
// A result held in the output register stalls the parse step only when it
// is not taken; ready on the input follows the output side in the same cycle.
module ppm_p6_stream_decoder #(
  parameter int unsigned MAX_DIM    = ppd_pkg::MAX_DIM_DEF,
  parameter int unsigned MAX_DIGITS = ppd_pkg::MAX_DIGITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ppd_in_if.sink    in_i,
  ppd_out_if.source out_o
);

  ppd_pkg::item_t in_item, item;
  ppd_pkg::res_t  res, out_res;
  logic           item_vld, advance, res_vld, out_vld;

  assign in_item.in_byte       = in_i.in_byte;
  assign in_item.start_of_file = in_i.start_of_file;

  // Step the parser when a byte is held and the result slot is free or being taken
  assign advance = item_vld && (!out_vld || out_o.ready);

  ppd_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .in_item_i    (in_item),
    .advance_i    (advance),
    .item_valid_o (item_vld),
    .item_o       (item)
  );

  ppd_parser #(
    .MAX_DIM    (MAX_DIM),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .item_i      (item),
    .res_valid_o (res_vld),
    .res_o       (res)
  );

  ppd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_vld),
    .res_i       (res),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_vld),
    .res_o       (out_res)
  );

  assign out_o.valid        = out_vld;
  assign out_o.kind         = out_res.kind;
  assign out_o.pixel_argb   = out_res.pixel_argb;
  assign out_o.image_width  = out_res.image_width;
  assign out_o.image_height = out_res.image_height;
  assign out_o.error_code   = out_res.error_code;
  assign out_o.last_pixel   = out_res.last_pixel;

endmodule

// File: hdl/ppd_in_stage.sv
// Input register stage holding one file byte request.
module ppd_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ppd_pkg::item_t  in_item_i,
  input  logic            advance_i,
  output logic            item_valid_o,
  output ppd_pkg::item_t  item_o
);

  logic           vld_q;
  ppd_pkg::item_t item_q;

  // Take a new request when empty or when the held one moves on
  assign in_ready_o   = !vld_q || advance_i;
  assign item_valid_o = vld_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  // Capture payload on accept
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

endmodule

// File: hdl/ppd_parser.sv
// Header parser and pixel packer: parse state plus one step of next-state logic.
module ppd_parser #(
  parameter int unsigned MAX_DIM    = ppd_pkg::MAX_DIM_DEF,
  parameter int unsigned MAX_DIGITS = ppd_pkg::MAX_DIGITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           advance_i,
  input  ppd_pkg::item_t item_i,
  output logic           res_valid_o,
  output ppd_pkg::res_t  res_o
);

  localparam int unsigned AccW  = $clog2(MAX_DIM + 2);
  localparam int unsigned ProdW = AccW + 4;
  localparam int unsigned CntW  = $clog2(MAX_DIGITS + 2);
  localparam int unsigned PixW  = 2 * AccW;

  localparam logic [7:0] CharP  = 8'h50;
  localparam logic [7:0] Char6  = 8'h36;
  localparam logic [7:0] Alpha  = 8'hff;

  typedef enum logic [3:0] {
    PH_MAGIC_P, PH_MAGIC_6, PH_SEP_MAGIC, PH_SKIP_WS,
    PH_WIDTH, PH_HEIGHT, PH_MAXVAL, PH_PIXELS, PH_HALT
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [AccW-1:0] acc_q, acc_d;
  logic            over_q, over_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [AccW-1:0] w_q, w_d;
  logic [AccW-1:0] h_q, h_d;
  logic [1:0]      ch_q, ch_d;
  logic [15:0]     rg_q, rg_d;
  logic [PixW-1:0] left_q, left_d;

  logic            res_vld;
  ppd_pkg::res_t   res;

  phase_e          ph, num_ph;
  logic            num_en;
  logic [7:0]      b;
  logic            is_ws, is_dig;
  logic [ProdW-1:0] prod;
  logic [CntW-1:0]  cnt_n;

  assign b      = item_i.in_byte;
  assign is_ws  = (b == 8'h20) || (b == 8'h09) || (b == 8'h0a) || (b == 8'h0d);
  assign is_dig = (b >= 8'h30) && (b <= 8'h39);

  // Next state and result for the held byte
  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    over_d  = over_q;
    cnt_d   = cnt_q;
    w_d     = w_q;
    h_d     = h_q;
    ch_d    = ch_q;
    rg_d    = rg_q;
    left_d  = left_q;
    res_vld = 1'b0;
    res     = '{kind: ppd_pkg::KIND_PIXEL, pixel_argb: '0, image_width: '0,
                image_height: '0, error_code: ppd_pkg::ERR_MAGIC, last_pixel: 1'b0};
    num_en  = 1'b0;
    num_ph  = phase_q;
    prod    = '0;
    cnt_n   = '0;

    // Restart on a file start
    ph = phase_q;
    if (item_i.start_of_file) begin
      ph     = PH_MAGIC_P;
      num_ph = PH_MAGIC_P;
      acc_d  = '0;
      over_d = 1'b0;
      cnt_d  = '0;
      w_d    = '0;
      h_d    = '0;
      ch_d   = '0;
      rg_d   = '0;
      left_d = '0;
    end

    case (ph)
      PH_MAGIC_P: begin
        if (b != CharP) begin
          res_vld = 1'b1;
          res.kind = ppd_pkg::KIND_ERROR;
          res.error_code = ppd_pkg::ERR_MAGIC;
          phase_d = PH_HALT;
        end else begin
          phase_d = PH_MAGIC_6;
        end
      end
      PH_MAGIC_6: begin
        if (b != Char6) begin
          res_vld = 1'b1;
          res.kind = ppd_pkg::KIND_ERROR;
          res.error_code = ppd_pkg::ERR_MAGIC;
          phase_d = PH_HALT;
        end else begin
          phase_d = PH_SEP_MAGIC;
        end
      end
      PH_SEP_MAGIC: begin
        if (!is_ws) begin
          res_vld = 1'b1;
          res.kind = ppd_pkg::KIND_ERROR;
          res.error_code = ppd_pkg::ERR_SEP;
          phase_d = PH_HALT;
        end else begin
          phase_d = PH_SKIP_WS;
        end
      end
      PH_SKIP_WS: begin
        // First non-blank byte opens the width
        if (!is_ws) begin
          num_en = 1'b1;
          num_ph = PH_WIDTH;
          acc_d  = '0;
          over_d = 1'b0;
          cnt_d  = '0;
        end
      end
      PH_WIDTH, PH_HEIGHT, PH_MAXVAL: begin
        num_en = 1'b1;
        num_ph = ph;
      end
      PH_PIXELS: begin
        case (ch_q)
          2'd0: begin
            rg_d = {b, 8'h00};
            ch_d = 2'd1;
          end
          2'd1: begin
            rg_d = {rg_q[15:8], b};
            ch_d = 2'd2;
          end
          default: begin
            // Blue byte closes the pixel
            ch_d   = 2'd0;
            left_d = left_q - PixW'(1);
            res_vld = 1'b1;
            res.kind = ppd_pkg::KIND_PIXEL;
            res.pixel_argb = {Alpha, rg_q, b};
            res.image_width = ppd_pkg::DIM_W'(w_q);
            res.image_height = ppd_pkg::DIM_W'(h_q);
            res.last_pixel = (left_q == PixW'(1));
            if (left_q == PixW'(1)) begin
              phase_d = PH_HALT;
            end
          end
        endcase
      end
      default: begin
        // Halted: drop bytes until a file start
      end
    endcase

    // Decimal number field
    if (num_en) begin
      phase_d = num_ph;
      if (is_dig) begin
        cnt_n = cnt_d + CntW'(1);
        cnt_d = cnt_n;
        if (cnt_n > CntW'(MAX_DIGITS)) begin
          res_vld = 1'b1;
          res.kind = ppd_pkg::KIND_ERROR;
          res.error_code = ppd_pkg::ERR_NUMBER;
          phase_d = PH_HALT;
        end else if (!over_d) begin
          prod = ({4'b0, acc_d} << 3) + ({4'b0, acc_d} << 1) + ProdW'(b[3:0]);
          if (prod > ProdW'(MAX_DIM)) begin
            over_d = 1'b1;
            acc_d  = AccW'(MAX_DIM + 1);
          end else begin
            acc_d  = AccW'(prod);
          end
        end
      end else if (cnt_d == '0) begin
        res_vld = 1'b1;
        res.kind = ppd_pkg::KIND_ERROR;
        res.error_code = ppd_pkg::ERR_NUMBER;
        phase_d = PH_HALT;
      end else if (!is_ws) begin
        res_vld = 1'b1;
        res.kind = ppd_pkg::KIND_ERROR;
        res.error_code = ppd_pkg::ERR_SEP;
        phase_d = PH_HALT;
      end else if ((num_ph == PH_WIDTH || num_ph == PH_HEIGHT) && over_d) begin
        res_vld = 1'b1;
        res.kind = ppd_pkg::KIND_ERROR;
        res.error_code = ppd_pkg::ERR_SIZE;
        phase_d = PH_HALT;
      end else begin
        acc_d  = '0;
        over_d = 1'b0;
        cnt_d  = '0;
        if (num_ph == PH_WIDTH) begin
          w_d     = acc_q;
          phase_d = PH_HEIGHT;
        end else if (num_ph == PH_HEIGHT) begin
          h_d     = acc_q;
          phase_d = PH_MAXVAL;
        end else begin
          // Header done: report size and arm the pixel count
          left_d  = PixW'(w_q) * PixW'(h_q);
          ch_d    = '0;
          rg_d    = '0;
          phase_d = (w_q == '0 || h_q == '0) ? PH_HALT : PH_PIXELS;
          res_vld = 1'b1;
          res.kind = ppd_pkg::KIND_HEADER;
          res.image_width = ppd_pkg::DIM_W'(w_q);
          res.image_height = ppd_pkg::DIM_W'(h_q);
        end
      end
    end
  end

  assign res_valid_o = advance_i && res_vld;
  assign res_o       = res;

  // Hold parse state; advance once per request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_MAGIC_P;
      acc_q   <= '0;
      over_q  <= 1'b0;
      cnt_q   <= '0;
      w_q     <= '0;
      h_q     <= '0;
      ch_q    <= '0;
      rg_q    <= '0;
      left_q  <= '0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      over_q  <= over_d;
      cnt_q   <= cnt_d;
      w_q     <= w_d;
      h_q     <= h_d;
      ch_q    <= ch_d;
      rg_q    <= rg_d;
      left_q  <= left_d;
    end
  end

endmodule

// File: hdl/ppd_out_stage.sv
// Result register that holds one decoded result until it is taken.
module ppd_out_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  ppd_pkg::res_t  res_i,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  output ppd_pkg::res_t  res_o
);

  logic          vld_q;
  ppd_pkg::res_t res_q;

  assign out_valid_o = vld_q;
  assign res_o       = res_q;

  // Set on load, clear once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load_i) begin
      vld_q <= 1'b1;
    end else if (out_ready_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

// File: hdl/ppd_checker.sv
// Port-level checks for the PPM P6 stream decoder, bound to the top level.
module ppd_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [1:0]                 kind_i,
  input logic [ppd_pkg::ARGB_W-1:0] pixel_argb_i,
  input logic [1:0]                 error_code_i,
  input logic                       last_pixel_i
);

  // Stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(pixel_argb_i) && $stable(kind_i))
    else $error("stalled result changed");

  // Kind code never unused
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> kind_i != 2'd3)
    else $error("unused result kind");

  // Pixels are opaque
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == ppd_pkg::KIND_PIXEL |-> pixel_argb_i[31:24] == 8'hff)
    else $error("pixel alpha not opaque");

  // Last flag only on pixels
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && last_pixel_i |-> kind_i == ppd_pkg::KIND_PIXEL)
    else $error("last flag on non-pixel result");

  // Non-error results carry no error code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i != ppd_pkg::KIND_ERROR |-> error_code_i == 2'd0)
    else $error("error code on non-error result");

endmodule

bind ppm_p6_stream_decoder ppd_checker u_ppd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .kind_i       (out_o.kind),
  .pixel_argb_i (out_o.pixel_argb),
  .error_code_i (out_o.error_code),
  .last_pixel_i (out_o.last_pixel)
);

// File: dv/ppm_p6_stream_decoder_tb.sv
// Self-checking testbench for the PPM P6 stream decoder with random PPM files.
`timescale 1ns / 100ps

module ppm_p6_stream_decoder_tb;

  localparam int unsigned CLK_PERIOD   = 12;
  localparam int unsigned RESET_CYCLES = 11;
  localparam int unsigned LIMIT_CYCLES = 300000;
  localparam int unsigned RANDOM_BYTES = 550;
  localparam int unsigned PHASE_BYTES  = 70;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned MAX_DIM      = ppd_pkg::MAX_DIM_DEF;
  localparam int unsigned MAX_DIGITS   = ppd_pkg::MAX_DIGITS_DEF;

  // Characters the header grammar cares about
  localparam logic [7:0] CH_P         = 8'h50;
  localparam logic [7:0] CH_SIX       = 8'h36;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_NINE      = 8'h39;
  localparam logic [7:0] CH_SP        = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef enum logic [3:0] {
    ST_MAGIC_P, ST_MAGIC_6, ST_SEP_MAGIC, ST_SKIP_WS,
    ST_WIDTH, ST_HEIGHT, ST_MAXVAL, ST_PIXELS, ST_HALT
  } parse_st_e;

  typedef enum int {
    FAULT_NONE, FAULT_MAGIC_P, FAULT_MAGIC_6, FAULT_SEP,
    FAULT_EMPTY, FAULT_LONG, FAULT_NONDIGIT, FAULT_OVERSIZE
  } fault_e;

  typedef enum int {
    IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH
  } idle_mode_e;

  // One file byte waiting to be sent; hold_off waits for all results first
  typedef struct packed {
    logic           hold_off;
    ppd_pkg::item_t item;
  } feed_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ppd_in_if  byte_if ();
  ppd_out_if result_if ();

  ppm_p6_stream_decoder #(
    .MAX_DIM    (MAX_DIM),
    .MAX_DIGITS (MAX_DIGITS)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_if),
    .out_o  (result_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Decoder state as seen by the predictor
  parse_st_e                 st;
  logic [ppd_pkg::DIM_W-1:0] acc;
  logic                      acc_over;
  logic [3:0]                ndigits;
  logic [ppd_pkg::DIM_W-1:0] img_w;
  logic [ppd_pkg::DIM_W-1:0] img_h;
  logic [1:0]                chan;
  logic [15:0]               rg_hold;
  logic [24:0]               pix_left;

  feed_t         file_bytes_q[$];
  ppd_pkg::res_t decoded_q[$];
  int unsigned   cycle_count    = 0;
  int unsigned   accepted_bytes = 0;
  int unsigned   fail_count     = 0;
  int unsigned   fed_bytes      = 0;
  bit            byte_taken     = 1'b0;

  function automatic bit is_ws(logic [7:0] b);
    return b == CH_SP || b == CH_TAB || b == CH_LF || b == CH_CR;
  endfunction

  function automatic bit is_digit(logic [7:0] b);
    return b >= CH_ZERO && b <= CH_NINE;
  endfunction

  task automatic clear_number();
    acc      = '0;
    acc_over = 1'b0;
    ndigits  = '0;
  endtask

  task automatic restart_parse();
    st = ST_MAGIC_P;
    clear_number();
    img_w    = '0;
    img_h    = '0;
    chan     = '0;
    rg_hold  = '0;
    pix_left = '0;
  endtask

  task automatic raise_error(input ppd_pkg::err_e code);
    ppd_pkg::res_t r;
    r            = '0;
    r.kind       = ppd_pkg::KIND_ERROR;
    r.error_code = code;
    decoded_q.push_back(r);
    st = ST_HALT;
  endtask

  // Advance the parse by one file byte and queue the result it causes
  task automatic decode_byte(input logic [7:0] b, input logic sof);
    ppd_pkg::res_t r;
    int unsigned   v;
    r = '0;
    if (sof) restart_parse();
    // first non-blank after the magic opens the width
    if (st == ST_SKIP_WS && !is_ws(b)) begin
      clear_number();
      st = ST_WIDTH;
    end
    case (st)
      ST_MAGIC_P: if (b != CH_P) raise_error(ppd_pkg::ERR_MAGIC); else st = ST_MAGIC_6;
      ST_MAGIC_6: if (b != CH_SIX) raise_error(ppd_pkg::ERR_MAGIC); else st = ST_SEP_MAGIC;
      ST_SEP_MAGIC: if (!is_ws(b)) raise_error(ppd_pkg::ERR_SEP); else st = ST_SKIP_WS;
      ST_WIDTH, ST_HEIGHT, ST_MAXVAL: begin
        if (is_digit(b)) begin
          ndigits = ndigits + 4'd1;
          if (ndigits > MAX_DIGITS) begin
            raise_error(ppd_pkg::ERR_NUMBER);
          end else if (!acc_over) begin
            // saturate just above the size limit
            v = 32'(acc) * 32'd10 + 32'(b) - 32'(CH_ZERO);
            if (v > MAX_DIM) begin
              acc_over = 1'b1;
              acc      = ppd_pkg::DIM_W'(MAX_DIM + 1);
            end else begin
              acc = ppd_pkg::DIM_W'(v);
            end
          end
        end else if (ndigits == 0) begin
          raise_error(ppd_pkg::ERR_NUMBER);
        end else if (!is_ws(b)) begin
          raise_error(ppd_pkg::ERR_SEP);
        end else if (st != ST_MAXVAL && acc_over) begin
          raise_error(ppd_pkg::ERR_SIZE);
        end else if (st == ST_WIDTH) begin
          img_w = acc;
          clear_number();
          st = ST_HEIGHT;
        end else if (st == ST_HEIGHT) begin
          img_h = acc;
          clear_number();
          st = ST_MAXVAL;
        end else begin
          clear_number();
          pix_left = 25'(32'(img_w) * 32'(img_h));
          chan     = '0;
          rg_hold  = '0;
          st       = (pix_left == 0) ? ST_HALT : ST_PIXELS;
          r.kind         = ppd_pkg::KIND_HEADER;
          r.image_width  = img_w;
          r.image_height = img_h;
          decoded_q.push_back(r);
        end
      end
      ST_PIXELS: begin
        if (chan == 2'd0) begin
          rg_hold = {b, 8'h00};
          chan    = 2'd1;
        end else if (chan == 2'd1) begin
          rg_hold = {rg_hold[15:8], b};
          chan    = 2'd2;
        end else begin
          chan     = 2'd0;
          pix_left = pix_left - 25'd1;
          r.kind         = ppd_pkg::KIND_PIXEL;
          r.pixel_argb   = {ALPHA_OPAQUE, rg_hold, b};
          r.image_width  = img_w;
          r.image_height = img_h;
          r.last_pixel   = (pix_left == 0);
          if (pix_left == 0) st = ST_HALT;
          decoded_q.push_back(r);
        end
      end
      // blanks after the magic and everything after a halt give nothing
      default: ;
    endcase
  endtask

  task automatic push_byte(input logic [7:0] b, input logic sof, input bit hold);
    feed_t f;
    f.hold_off           = hold;
    f.item.in_byte       = b;
    f.item.start_of_file = sof;
    file_bytes_q.push_back(f);
    fed_bytes++;
  endtask

  task automatic push_text(input string s, input logic sof, input bit hold);
    for (int i = 0; i < s.len(); i++) begin
      push_byte(s[i], (i == 0) ? sof : 1'b0, (i == 0) ? hold : 1'b0);
    end
  endtask

  function automatic logic [7:0] any_ws();
    case ($urandom_range(3))
      0: return CH_SP;
      1: return CH_TAB;
      2: return CH_LF;
      default: return CH_CR;
    endcase
  endfunction

  // A byte that is neither a digit nor a blank
  function automatic logic [7:0] junk_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (is_digit(b) || is_ws(b));
    return b;
  endfunction

  // Emit a decimal number of at most MAX_DIGITS digits, optionally zero-padded
  task automatic push_decimal(input longint unsigned value, input bit pad);
    logic [7:0]        digs[$];
    longint unsigned   v;
    int unsigned       zeros;
    v = value;
    do begin
      digs.push_front(CH_ZERO + 8'(v % 10));
      v = v / 10;
    end while (v != 0);
    zeros = pad ? $urandom_range(MAX_DIGITS - digs.size()) : 0;
    repeat (zeros) push_byte(CH_ZERO, 1'b0, 1'b0);
    foreach (digs[i]) push_byte(digs[i], 1'b0, 1'b0);
  endtask

  // Build one file: well-formed for about half the draws, otherwise broken at one point or raw noise
  task automatic gen_file();
    int unsigned     sel;
    fault_e          fault;
    int unsigned     bad_field;
    longint unsigned dims[3];
    longint unsigned tmp;
    int unsigned     npix;
    int unsigned     nbytes;
    logic [7:0]      b;
    bit              hold;
    sel       = $urandom_range(99);
    hold      = ($urandom_range(5) == 0);
    fault     = FAULT_NONE;
    bad_field = $urandom_range(2);
    dims[0]   = $urandom_range(3);
    dims[1]   = $urandom_range(3);
    case ($urandom_range(3))
      0: dims[2] = 255;
      1: dims[2] = $urandom_range(9);
      default: dims[2] = longint'($urandom);
    endcase

    // raw noise, now and then with a file start
    if (sel >= 94) begin
      repeat ($urandom_range(1, 8)) begin
        push_byte(8'($urandom_range(255)), ($urandom_range(7) == 0), 1'b0);
      end
      return;
    end

    if (sel >= 45 && sel < 50) begin
      dims[0] = $urandom_range(1) ? MAX_DIM : MAX_DIM - 1;
      dims[1] = $urandom_range(1) ? MAX_DIM : 1;
      if ($urandom_range(1)) begin
        tmp     = dims[0];
        dims[0] = dims[1];
        dims[1] = tmp;
      end
    end else if (sel >= 88) fault = FAULT_NONDIGIT;
    else if (sel >= 82) fault = FAULT_LONG;
    else if (sel >= 75) fault = FAULT_EMPTY;
    else if (sel >= 69) fault = FAULT_SEP;
    else if (sel >= 63) fault = FAULT_MAGIC_6;
    else if (sel >= 57) fault = FAULT_MAGIC_P;
    else if (sel >= 50) fault = FAULT_OVERSIZE;
    if (fault == FAULT_OVERSIZE) bad_field = $urandom_range(1);

    // magic and the blanks after it
    if (fault == FAULT_MAGIC_P) begin
      do b = 8'($urandom_range(255)); while (b == CH_P);
      push_byte(b, 1'b1, hold);
      return;
    end
    push_byte(CH_P, 1'b1, hold);
    if (fault == FAULT_MAGIC_6) begin
      do b = 8'($urandom_range(255)); while (b == CH_SIX);
      push_byte(b, 1'b0, 1'b0);
      return;
    end
    push_byte(CH_SIX, 1'b0, 1'b0);
    if (fault == FAULT_SEP) begin
      push_byte(junk_byte(), 1'b0, 1'b0);
      return;
    end
    repeat ($urandom_range(1, 3)) push_byte(any_ws(), 1'b0, 1'b0);

    // width, height and maximum value, each with one blank after it
    for (int f = 0; f < 3; f++) begin
      if (fault != FAULT_NONE && f == bad_field) begin
        case (fault)
          FAULT_EMPTY: begin
            push_byte((f != 0 && $urandom_range(1)) ? any_ws() : junk_byte(), 1'b0, 1'b0);
          end
          FAULT_LONG: begin
            repeat (MAX_DIGITS + 1 + $urandom_range(1)) begin
              push_byte(CH_ZERO + 8'($urandom_range(9)), 1'b0, 1'b0);
            end
          end
          FAULT_NONDIGIT: begin
            push_decimal(dims[f], ($urandom_range(3) == 0));
            push_byte(junk_byte(), 1'b0, 1'b0);
          end
          default: begin
            tmp = $urandom_range(1) ? longint'(MAX_DIM + 1 + $urandom_range(3))
                                    : longint'($urandom) * 2 + MAX_DIM + 1;
            push_decimal(tmp, ($urandom_range(3) == 0));
            push_byte(any_ws(), 1'b0, 1'b0);
          end
        endcase
        return;
      end
      push_decimal(dims[f], ($urandom_range(5) == 0));
      push_byte(any_ws(), 1'b0, 1'b0);
    end

    // pixel data; large images are always cut short by the next file
    npix = int'(dims[0] * dims[1]);
    if (sel >= 45) nbytes = $urandom_range(30);
    else if ($urandom_range(9) == 0) nbytes = $urandom_range(3 * npix);
    else nbytes = 3 * npix;
    repeat (nbytes) push_byte(8'($urandom_range(255)), 1'b0, 1'b0);
  endtask

  // Drive requests and result ready at the falling edge
  always @(negedge clk_i) begin : drive_requests
    idle_mode_e mode;
    bit         idle_now;
    bit         stall_now;
    mode      = idle_mode_e'((accepted_bytes / PHASE_BYTES) % 4);
    idle_now  = (mode == IDLE_SENDER && $urandom_range(99) < 80) ||
                (mode == IDLE_BOTH && $urandom_range(99) < 28);
    stall_now = (mode == IDLE_RECEIVER && $urandom_range(99) < 80) ||
                (mode == IDLE_BOTH && $urandom_range(99) < 28);
    if (!rst_ni) begin
      byte_if.valid   <= 1'b0;
      result_if.ready <= 1'b0;
    end else begin
      // hold an offered request until it is taken
      if (!byte_if.valid || byte_taken) begin
        byte_taken = 1'b0;
        if (file_bytes_q.size() != 0 && !idle_now &&
            !(file_bytes_q[0].hold_off && decoded_q.size() != 0)) begin
          byte_if.valid         <= 1'b1;
          byte_if.in_byte       <= file_bytes_q[0].item.in_byte;
          byte_if.start_of_file <= file_bytes_q[0].item.start_of_file;
        end else begin
          byte_if.valid <= 1'b0;
        end
      end
      result_if.ready <= !stall_now;
    end
  end

  // Check results and predict from accepted requests at the rising edge
  always @(posedge clk_i) begin : check_results
    ppd_pkg::res_t want;
    if (rst_ni) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        if (result_if.valid && result_if.ready) begin
          if (decoded_q.size() == 0) begin
            $error("unexpected result: kind %0d", result_if.kind);
            fail_count++;
          end else begin
            want = decoded_q.pop_front();
            if (result_if.kind !== want.kind) begin
              $error("kind: expected %0d, actual %0d", want.kind, result_if.kind);
              fail_count++;
            end
            if (result_if.pixel_argb !== want.pixel_argb) begin
              $error("pixel_argb: expected %08h, actual %08h", want.pixel_argb,
                     result_if.pixel_argb);
              fail_count++;
            end
            if (result_if.image_width !== want.image_width) begin
              $error("image_width: expected %0d, actual %0d", want.image_width,
                     result_if.image_width);
              fail_count++;
            end
            if (result_if.image_height !== want.image_height) begin
              $error("image_height: expected %0d, actual %0d", want.image_height,
                     result_if.image_height);
              fail_count++;
            end
            if (result_if.error_code !== want.error_code) begin
              $error("error_code: expected %0d, actual %0d", want.error_code,
                     result_if.error_code);
              fail_count++;
            end
            if (result_if.last_pixel !== want.last_pixel) begin
              $error("last_pixel: expected %0d, actual %0d", want.last_pixel,
                     result_if.last_pixel);
              fail_count++;
            end
          end
        end
        if (byte_if.valid && byte_if.ready) begin
          decode_byte(byte_if.in_byte, byte_if.start_of_file);
          void'(file_bytes_q.pop_front());
          byte_taken = 1'b1;
          accepted_bytes++;
        end
      end
    end
  end

  initial begin : run_test
    int unsigned directed_end;
    byte_if.valid         = 1'b0;
    byte_if.in_byte       = '0;
    byte_if.start_of_file = 1'b0;
    result_if.ready       = 1'b0;
    restart_parse();

    // first file right after reset, without the start flag: one pixel
    push_text("P6 1 1 9 ", 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'h80, 1'b0, 1'b0);
    // ignored after the last pixel
    push_byte(8'h41, 1'b0, 1'b0);
    // bad magic, sent only once every result is out
    push_byte(8'h5A, 1'b1, 1'b1);
    // zero size with tab, CR and LF blanks: header only
    push_text("P6\t0", 1'b1, 1'b0);
    push_byte(CH_CR, 1'b0, 1'b0);
    push_text("7\n5\n", 1'b0, 1'b0);

    directed_end = fed_bytes;
    while (fed_bytes < directed_end + RANDOM_BYTES) begin
      gen_file();
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(255)), 1'b0, 1'b0);
      end
    end

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (file_bytes_q.size() != 0 || decoded_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/ppd_pkg.sv
hdl/ppd_if.sv
hdl/ppd_in_stage.sv
hdl/ppd_parser.sv
hdl/ppd_out_stage.sv
hdl/ppm_p6_stream_decoder.sv
hdl/ppd_checker.sv
dv/ppm_p6_stream_decoder_tb.sv
